### hdl/npc_pkg.sv
// Shared types, constants and helpers for the nearest palette color search.
package npc_pkg;

   // Default sizes for the palette storage
   localparam int DEFAULT_ENTRIES    = 256;
   localparam int DEFAULT_PIXEL_BITS = 32;

   // Fixed field widths of the request, response and CSR channels
   localparam int COLOR_W = 16;
   localparam int CHAN_W  = 8;
   localparam int RGB_W   = 3 * CHAN_W;
   localparam int SLOT_W  = 8;
   localparam int PIXEL_W = 32;
   localparam int DIST_W  = 18;
   localparam int COUNT_W = 9;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;
   localparam logic [DIST_W-1:0]  NO_DISTANCE = '1;

   // Request kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // Search sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // Square of the absolute difference of two color channels
   function automatic logic [2*CHAN_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
      logic [CHAN_W-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return (2*CHAN_W)'(d) * (2*CHAN_W)'(d);
   endfunction

endpackage

### hdl/npc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module npc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/nearest_palette_color.sv
// Top level of the nearest palette color search: sequencer, distance unit, result register.
//
// Usage:
//   csr_*  : write entries_in_use (9 bits, reset 256); values above ENTRIES
//            search the whole palette. csr_ready is always high.
//   req_*  : a load request (req_kind = 0) writes slot req_entry_index with the
//            high bytes of red, green, blue and the pixel value; slots at or
//            beyond ENTRIES are dropped. A query request (req_kind = 1) searches
//            the first N = min(entries_in_use, ENTRIES) slots.
//   rsp_*  : one response per query: pixel, slot and squared distance of the
//            first strictly nearest entry; pixel 0, slot 0, all-ones distance
//            when N is 0.
// Timing: a query reads one palette word per cycle from the single RAM read
//   port; req_ready stays low from the accepted request until its result is
//   loaded into the output register.
// Stalls: the response sits in an output register; loads and the next query
//   are taken while it waits, and a finished query holds until it drains.
// Reset: clears control state and restores entries_in_use to 256; palette
//   contents are undefined until loaded.
module nearest_palette_color #(
   parameter int ENTRIES    = npc_pkg::DEFAULT_ENTRIES,
   parameter int PIXEL_BITS = npc_pkg::DEFAULT_PIXEL_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [npc_pkg::COUNT_W-1:0]  csr_entries_in_use,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_kind,
   input  logic [npc_pkg::SLOT_W-1:0]   req_entry_index,
   input  logic [npc_pkg::COLOR_W-1:0]  req_red,
   input  logic [npc_pkg::COLOR_W-1:0]  req_green,
   input  logic [npc_pkg::COLOR_W-1:0]  req_blue,
   input  logic [npc_pkg::PIXEL_W-1:0]  req_pixel_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [npc_pkg::PIXEL_W-1:0]  rsp_best_pixel,
   output logic [npc_pkg::SLOT_W-1:0]   rsp_best_index,
   output logic [npc_pkg::DIST_W-1:0]   rsp_best_distance
);

   import npc_pkg::*;

   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int SCMP_W = CNT_W + SLOT_W;
   localparam int WORD_W = RGB_W + PIXEL_BITS;

   // State and registers
   state_type            state_ff, state_in;
   logic [COUNT_W-1:0]   entries_in_use_ff;
   logic [CNT_W-1:0]     count_ff, addr_ff;
   logic [CHAN_W-1:0]    q_red_ff, q_green_ff, q_blue_ff;
   logic                 rd_valid_ff;
   logic [IDX_W-1:0]     rd_idx_ff;
   logic                 dist_valid_ff;
   logic [IDX_W-1:0]     dist_idx_ff;
   logic [DIST_W-1:0]    dist_ff;
   logic [PIXEL_BITS-1:0] dist_pix_ff;
   logic [DIST_W-1:0]    best_dist_ff;
   logic [IDX_W-1:0]     best_idx_ff;
   logic [PIXEL_BITS-1:0] best_pix_ff;
   logic                 rsp_valid_ff;
   logic [PIXEL_W-1:0]   rsp_pixel_ff;
   logic [SLOT_W-1:0]    rsp_index_ff;
   logic [DIST_W-1:0]    rsp_dist_ff;

   // Combinational signals
   logic                 accept_req, accept_query, accept_load;
   logic                 issue, out_load, scan_last, slot_ok;
   logic [CMP_W-1:0]     cfg_ext, count_clamped;
   logic [CNT_W-1:0]     count_in;
   logic [CNT_W-1:0]     addr_next;
   logic [SCMP_W-1:0]    slot_ext;
   logic [WORD_W-1:0]    wr_word, rd_word;
   logic [RGB_W-1:0]     rd_rgb;
   logic [PIXEL_BITS-1:0] rd_pix;
   logic [PIXEL_BITS+PIXEL_W-1:0] pix_in_ext;
   logic [PIXEL_BITS+PIXEL_W-1:0] pix_out_ext;
   logic [IDX_W+SLOT_W-1:0] idx_out_ext;
   logic [DIST_W-1:0]    dist_in;

   // Configuration register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_in_use_ff <= COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         entries_in_use_ff <= csr_entries_in_use;
      end
   end

   // Clamp the search count to the palette size
   assign cfg_ext       = CMP_W'(entries_in_use_ff);
   assign count_clamped = (cfg_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cfg_ext;
   assign count_in      = count_clamped[CNT_W-1:0];

   // Request decode
   assign accept_req   = req_valid && req_ready;
   assign accept_query = accept_req && (req_kind == KIND_QUERY);
   assign slot_ext     = SCMP_W'(req_entry_index);
   assign slot_ok      = slot_ext < SCMP_W'(ENTRIES);
   assign accept_load  = accept_req && (req_kind == KIND_LOAD) && slot_ok;

   // Pack the palette word: channel high bytes and the pixel
   assign pix_in_ext = {{PIXEL_BITS{1'b0}}, req_pixel_value};
   assign wr_word    = {req_red[COLOR_W-1 -: CHAN_W], req_green[COLOR_W-1 -: CHAN_W],
                        req_blue[COLOR_W-1 -: CHAN_W], pix_in_ext[PIXEL_BITS-1:0]};

   npc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (accept_load),
      .wr_addr (slot_ext[IDX_W-1:0]),
      .wr_data (wr_word),
      .rd_en   (issue),
      .rd_addr (addr_ff[IDX_W-1:0]),
      .rd_data (rd_word)
   );

   assign rd_rgb = rd_word[WORD_W-1 -: RGB_W];
   assign rd_pix = rd_word[PIXEL_BITS-1:0];

   // Distance unit: one palette word per cycle
   assign dist_in = DIST_W'(sq_diff(rd_rgb[RGB_W-1 -: CHAN_W], q_red_ff))
                  + DIST_W'(sq_diff(rd_rgb[CHAN_W +: CHAN_W], q_green_ff))
                  + DIST_W'(sq_diff(rd_rgb[CHAN_W-1:0], q_blue_ff));

   assign addr_next = addr_ff + CNT_W'(1);
   assign scan_last = (addr_next == count_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept_query) begin
               state_in = (count_in == '0) ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_valid_ff && !dist_valid_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      issue     = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_SCAN:  issue     = 1'b1;
         ST_DRAIN: ;
         ST_DONE:  out_load  = !rsp_valid_ff || rsp_ready;
         default:  ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_valid_ff   <= 1'b0;
         dist_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_valid_ff   <= issue;
         dist_valid_ff <= rd_valid_ff;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Query capture, address advance and distance pipeline
   always_ff @(posedge clock) begin
      if (accept_query) begin
         count_ff     <= count_in;
         addr_ff      <= '0;
         q_red_ff     <= req_red[COLOR_W-1 -: CHAN_W];
         q_green_ff   <= req_green[COLOR_W-1 -: CHAN_W];
         q_blue_ff    <= req_blue[COLOR_W-1 -: CHAN_W];
         best_dist_ff <= NO_DISTANCE;
         best_idx_ff  <= '0;
         best_pix_ff  <= '0;
      end else begin
         if (issue) begin
            addr_ff <= addr_next;
         end
         // Keep the first strictly nearest entry
         if (dist_valid_ff && (dist_ff < best_dist_ff)) begin
            best_dist_ff <= dist_ff;
            best_idx_ff  <= dist_idx_ff;
            best_pix_ff  <= dist_pix_ff;
         end
      end
      rd_idx_ff   <= addr_ff[IDX_W-1:0];
      dist_ff     <= dist_in;
      dist_idx_ff <= rd_idx_ff;
      dist_pix_ff <= rd_pix;
   end

   // Response register
   assign pix_out_ext = {{PIXEL_W{1'b0}}, best_pix_ff};
   assign idx_out_ext = {{SLOT_W{1'b0}}, best_idx_ff};

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_pixel_ff <= pix_out_ext[PIXEL_W-1:0];
         rsp_index_ff <= idx_out_ext[SLOT_W-1:0];
         rsp_dist_ff  <= best_dist_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_best_pixel    = rsp_pixel_ff;
   assign rsp_best_index    = rsp_index_ff;
   assign rsp_best_distance = rsp_dist_ff;

endmodule

### test/palette_match_checker.sv
// Checker for the nearest palette color search: mirrors the palette, predicts and compares responses.
module palette_match_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [npc_pkg::COUNT_W-1:0]  csr_entries_in_use,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic                         req_kind,
   input  logic [npc_pkg::SLOT_W-1:0]   req_entry_index,
   input  logic [npc_pkg::COLOR_W-1:0]  req_red,
   input  logic [npc_pkg::COLOR_W-1:0]  req_green,
   input  logic [npc_pkg::COLOR_W-1:0]  req_blue,
   input  logic [npc_pkg::PIXEL_W-1:0]  req_pixel_value,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [npc_pkg::PIXEL_W-1:0]  rsp_best_pixel,
   input  logic [npc_pkg::SLOT_W-1:0]   rsp_best_index,
   input  logic [npc_pkg::DIST_W-1:0]   rsp_best_distance,
   output int                           mismatches,
   output int                           outstanding
);

   import npc_pkg::*;

   localparam int ENTRIES = DEFAULT_ENTRIES;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic [SLOT_W-1:0]  index;
      logic [DIST_W-1:0]  distance;
   } match_type;

   // Mirror of the palette and of the search count
   logic [RGB_W-1:0]   shade [ENTRIES];
   logic [PIXEL_W-1:0] tag   [ENTRIES];
   logic [COUNT_W-1:0] search_count;
   match_type          owed_matches [$];

   // Scan the searched entries, keep the first strictly nearest one
   function automatic match_type nearest_entry(input logic [CHAN_W-1:0] r,
                                               input logic [CHAN_W-1:0] g,
                                               input logic [CHAN_W-1:0] b);
      match_type m;
      int        n;
      int        dr;
      int        dg;
      int        db;
      int        d;
      m.pixel    = '0;
      m.index    = '0;
      m.distance = NO_DISTANCE;
      n = (int'(search_count) > ENTRIES) ? ENTRIES : int'(search_count);
      for (int i = 0; i < n; i++) begin
         dr = int'(shade[i][23:16]) - int'(r);
         dg = int'(shade[i][15:8]) - int'(g);
         db = int'(shade[i][7:0]) - int'(b);
         d  = dr * dr + dg * dg + db * db;
         if (i == 0 || d < int'(m.distance)) begin
            m.pixel    = tag[i];
            m.index    = SLOT_W'(i);
            m.distance = DIST_W'(d);
         end
      end
      return m;
   endfunction

   task automatic flag_mismatch(input string text);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t: %s", $realtime, text);
      end
   endtask

   // Compare responses first, then take config writes and requests
   always @(posedge clock) begin : watch
      match_type got;
      match_type want;
      if (reset) begin
         search_count = COUNT_RESET;
         mismatches   = 0;
         owed_matches.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_best_pixel, rsp_best_index, rsp_best_distance};
            if (owed_matches.size() == 0) begin
               flag_mismatch($sformatf("unexpected response: pixel %h index %0d distance %0d",
                                       got.pixel, got.index, got.distance));
            end else begin
               want = owed_matches.pop_front();
               if (got !== want) begin
                  flag_mismatch($sformatf({"mismatch: expected pixel %h index %0d distance %0d,",
                                           " got pixel %h index %0d distance %0d"},
                                          want.pixel, want.index, want.distance,
                                          got.pixel, got.index, got.distance));
               end
            end
         end
         if (csr_valid && csr_ready) begin
            search_count = csr_entries_in_use;
         end
         if (req_valid && req_ready) begin
            if (req_kind == KIND_LOAD) begin
               shade[req_entry_index] = {req_red[15:8], req_green[15:8], req_blue[15:8]};
               tag[req_entry_index]   = req_pixel_value;
            end else begin
               owed_matches.push_back(nearest_entry(req_red[15:8], req_green[15:8],
                                                    req_blue[15:8]));
            end
         end
      end
      outstanding = owed_matches.size();
   end

endmodule

### test/tb_top.sv
// Testbench top for the nearest palette color search: clock, reset, stimulus and verdict.
module tb_top;
   import npc_pkg::*;

   localparam int ITEMS      = 1350;
   localparam int CALM_ITEMS = 150;

   logic                clock              = 1'b0;
   logic                reset              = 1'b1;
   logic                csr_valid          = 1'b0;
   logic                csr_ready;
   logic [COUNT_W-1:0]  csr_entries_in_use = '0;
   logic                req_valid          = 1'b0;
   logic                req_ready;
   logic                req_kind           = KIND_LOAD;
   logic [SLOT_W-1:0]   req_entry_index    = '0;
   logic [COLOR_W-1:0]  req_red            = '0;
   logic [COLOR_W-1:0]  req_green          = '0;
   logic [COLOR_W-1:0]  req_blue           = '0;
   logic [PIXEL_W-1:0]  req_pixel_value    = '0;
   logic                rsp_valid;
   logic                rsp_ready          = 1'b1;
   logic [PIXEL_W-1:0]  rsp_best_pixel;
   logic [SLOT_W-1:0]   rsp_best_index;
   logic [DIST_W-1:0]   rsp_best_distance;
   int                  mismatches;
   int                  outstanding;

   bit                  loaded [DEFAULT_ENTRIES];
   bit                  calm     = 1'b0;
   int                  sent     = 0;
   int                  gap_odds = 4;

   always #6 clock = ~clock;

   nearest_palette_color u_top (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_entries_in_use (csr_entries_in_use),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_entry_index    (req_entry_index),
      .req_red            (req_red),
      .req_green          (req_green),
      .req_blue           (req_blue),
      .req_pixel_value    (req_pixel_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_best_pixel     (rsp_best_pixel),
      .rsp_best_index     (rsp_best_index),
      .rsp_best_distance  (rsp_best_distance)
   );

   palette_match_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_entries_in_use (csr_entries_in_use),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_entry_index    (req_entry_index),
      .req_red            (req_red),
      .req_green          (req_green),
      .req_blue           (req_blue),
      .req_pixel_value    (req_pixel_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_best_pixel     (rsp_best_pixel),
      .rsp_best_index     (rsp_best_index),
      .rsp_best_distance  (rsp_best_distance),
      .mismatches         (mismatches),
      .outstanding        (outstanding)
   );

   // Color with a high byte drawn from a few popular values, so ties are common
   function automatic logic [COLOR_W-1:0] pick_color();
      logic [CHAN_W-1:0] hi;
      case ($urandom_range(0, 5))
         0: hi = 8'h00;
         1: hi = 8'hFF;
         2: hi = 8'h80;
         3: hi = 8'h7F;
         default: hi = CHAN_W'($urandom_range(0, 255));
      endcase
      return {hi, CHAN_W'($urandom_range(0, 255))};
   endfunction

   function automatic logic [PIXEL_W-1:0] pick_pixel();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   // Drive one request at a falling edge and hold it until accepted
   task automatic send(input logic kind, input logic [SLOT_W-1:0] slot,
                       input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                       input logic [COLOR_W-1:0] b, input logic [PIXEL_W-1:0] pix);
      if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_entry_index <= slot;
      req_red         <= r;
      req_green       <= g;
      req_blue        <= b;
      req_pixel_value <= pix;
      do @(posedge clock); while (!req_ready);
      if (kind == KIND_LOAD) begin
         loaded[slot] = 1'b1;
      end
      sent++;
      if (sent >= ITEMS - CALM_ITEMS) begin
         calm = 1'b1;
      end
      @(negedge clock);
   endtask

   task automatic load_random(input logic [SLOT_W-1:0] slot);
      send(KIND_LOAD, slot, pick_color(), pick_color(), pick_color(), pick_pixel());
   endtask

   task automatic query_random();
      send(KIND_QUERY, SLOT_W'($urandom_range(0, 255)), pick_color(), pick_color(),
           pick_color(), $urandom);
   endtask

   // Drop valid, wait for every response, then let a trailing load retire
   task automatic settle();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_count(input logic [COUNT_W-1:0] count);
      csr_valid          <= 1'b1;
      csr_entries_in_use <= count;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Load every searched slot that is still empty
   task automatic fill(input int count);
      int n;
      n = (count > DEFAULT_ENTRIES) ? DEFAULT_ENTRIES : count;
      for (int s = 0; s < n; s++) begin
         if (!loaded[s]) begin
            load_random(SLOT_W'(s));
         end
      end
   endtask

   // Ready on the response side: random stalls, none near the end
   initial begin
      @(negedge clock);
      forever begin
         if (calm || $urandom_range(0, 2) != 0) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
         end
      end
   end

   // Stimulus and verdict
   initial begin
      int phase;
      int count;
      int len;
      phase = 0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty palette
      write_count(9'd0);
      send(KIND_QUERY, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF);
      send(KIND_QUERY, 8'h00, 16'h0000, 16'h0000, 16'h0000, 32'h0);
      settle();

      // one entry: largest distance, low bytes ignored
      write_count(9'd1);
      send(KIND_LOAD, 8'h00, 16'h00FF, 16'h0000, 16'h00FF, 32'hFFFFFFFF);
      send(KIND_QUERY, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0);
      send(KIND_QUERY, 8'h00, 16'h00FF, 16'h00FF, 16'h00FF, 32'h0);
      settle();

      // three entries with a tie; a load beyond the searched range
      write_count(9'd3);
      send(KIND_LOAD, 8'h01, 16'hFF00, 16'hFFFF, 16'hFF00, 32'h0);
      send(KIND_LOAD, 8'h02, 16'h0000, 16'h0055, 16'h00AA, 32'h12345678);
      send(KIND_LOAD, 8'hFF, 16'h8000, 16'h8000, 16'h8000, 32'hA5A5A5A5);
      send(KIND_QUERY, 8'h00, 16'h0000, 16'h0000, 16'h0000, 32'h0);
      send(KIND_QUERY, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0);
      send(KIND_QUERY, 8'h00, 16'h7F80, 16'h8000, 16'h80FF, 32'h0);
      send(KIND_QUERY, 8'h00, 16'h4000, 16'hC000, 16'h2000, 32'h0);
      send(KIND_LOAD, 8'h01, 16'h0000, 16'h0000, 16'h0000, 32'h5A5A5A5A);
      send(KIND_QUERY, 8'h00, 16'h0100, 16'h0000, 16'h0000, 32'h0);

      // random phases, each under its own search count
      while (sent < ITEMS) begin
         case (phase)
            0: count = 511;
            1: count = 0;
            2: count = 256;
            default: begin
               case ($urandom_range(0, 19))
                  0: count = 0;
                  1: count = 256;
                  2: count = $urandom_range(257, 511);
                  3: count = 511;
                  4, 5: count = $urandom_range(17, 255);
                  default: count = $urandom_range(1, 16);
               endcase
            end
         endcase
         len      = (count > 16) ? 12 : $urandom_range(20, 60);
         gap_odds = ($urandom_range(0, 3) == 0) ? 0 : 3;
         settle();
         write_count(COUNT_W'(count));
         fill(count);
         repeat (len) begin
            if ($urandom_range(0, 1) == 0) begin
               load_random(SLOT_W'($urandom_range(0, 255)));
            end else begin
               query_random();
            end
         end
         phase++;
      end

      // drain and let any late response show up
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Hard stop in case the block hangs
   initial begin
      #(12 * 1500000);
      $display("Verification failed");
      $finish;
   end

endmodule
